@@ rtl/ocm_pkg.sv @@
// Package for the coarse occupancy change map: sizes, codes, types and helpers.
// Used by the interfaces, the divider and the top level. No dependencies.
`default_nettype none
package ocm_pkg;

   localparam int MAP_ROWS = 64;
   localparam int MAP_COLS = 64;
   localparam int ROW_AW   = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
   localparam int COL_AW   = (MAP_COLS > 1) ? $clog2(MAP_COLS) : 1;

   localparam int NUM_W    = 35;
   localparam int DEN_W    = 17;
   localparam int QUOT_W   = NUM_W + 1;
   localparam int KEY_W    = QUOT_W + 1;
   localparam int PROD_W   = 33;
   localparam int CNT_W    = $clog2(NUM_W + 1);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int MASK_W   = 64;
   localparam int COUNT_W  = 7;

   localparam logic signed [7:0] OCCUPIED_COST = 8'sd100;

   localparam logic [31:0] ORIGIN_RESET  = 32'd0;
   localparam logic [15:0] RES_RESET     = 16'd205;
   localparam logic [15:0] KEY_RESET     = 16'd1229;
   localparam logic [15:0] BASE_RESET    = 16'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ORIGIN_X   = 3'd0,
      REG_ORIGIN_Y   = 3'd1,
      REG_CELL_RES   = 3'd2,
      REG_KEY_SIZE   = 3'd3,
      REG_KEY_BASE_X = 3'd4,
      REG_KEY_BASE_Y = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      OP_BASELINE = 2'd0,
      OP_FINISH   = 2'd1,
      OP_UPDATE   = 2'd2,
      OP_READ_ROW = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_READ,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic                     done;
      logic signed [QUOT_W-1:0] quot;
   } div_res_type;

   function automatic logic [COUNT_W-1:0] popcount(input logic [MAP_COLS-1:0] v);
      logic [COUNT_W-1:0] c;
      c = '0;
      for (int i = 0; i < MAP_COLS; i++) begin
         c = c + COUNT_W'(v[i]);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

@@ rtl/ocm_if.sv @@
// Channel interfaces of the coarse occupancy change map: request, response, CSR.
// Depends on ocm_pkg for field widths.
`default_nettype none
interface ocm_req_if;
   import ocm_pkg::*;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [15:0] grid_col;
   logic [15:0] grid_row;
   logic signed [7:0] cost;
   logic [5:0]  read_index;
   modport source (output valid, opcode, grid_col, grid_row, cost, read_index,
                   input ready);
   modport sink (input valid, opcode, grid_col, grid_row, cost, read_index,
                 output ready);
endinterface

interface ocm_rsp_if;
   import ocm_pkg::*;
   logic               valid;
   logic               ready;
   logic [MASK_W-1:0]  row_mask;
   logic [COUNT_W-1:0] row_count;
   logic               map_ready;
   modport source (output valid, row_mask, row_count, map_ready, input ready);
   modport sink (input valid, row_mask, row_count, map_ready, output ready);
endinterface

interface ocm_csr_if;
   import ocm_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/ocm_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none
module ocm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                             clock,
   input  wire logic                             we,
   input  wire logic [$clog2(DEPTH)-1:0]         waddr,
   input  wire logic [WIDTH-1:0]                 wdata,
   input  wire logic [$clog2(DEPTH)-1:0]         raddr,
   output logic      [WIDTH-1:0]                 rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

@@ rtl/ocm_div.sv @@
// Restoring floor divider, one quotient bit per cycle, signed numerator.
// Depends on ocm_pkg.
`default_nettype none
module ocm_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic signed [ocm_pkg::NUM_W-1:0] num,
   input  wire logic [ocm_pkg::DEN_W-1:0]     den,
   output ocm_pkg::div_res_type               res
);
   import ocm_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 fin_ff, fin_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;
   logic [NUM_W-1:0]     mag_ff, mag_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic signed [QUOT_W-1:0] quot_ff, quot_in;
   logic [DEN_W:0]       trial;
   logic                 ge;

   always_comb begin
      trial   = {rem_ff, mag_ff[NUM_W-1]};
      ge      = (trial >= {1'b0, den_ff});
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = fin_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         neg_in  = num[NUM_W-1];
         mag_in  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = ge ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         mag_in = {mag_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
      if (fin_ff) begin
         quot_in = neg_ff ? -$signed({1'b0, mag_ff}) - QUOT_W'(rem_ff != '0)
                          : $signed({1'b0, mag_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign res.done = done_ff;
   assign res.quot = quot_ff;
endmodule
`default_nettype wire

@@ rtl/coarse_occupancy_change_map_core.sv @@
// Top level of the coarse occupancy change map: key quantizer, bitmaps, CSRs.
// Depends on ocm_pkg, the ocm_*_if interfaces, ocm_div and ocm_ram.
//
//   channel   dir   word
//   req_ch    in    opcode, grid_col, grid_row, cost, read_index
//   rsp_ch    out   row_mask, row_count, map_ready (read_row only)
//   csr_ch    in    index, data (always ready)
//
// A cell word runs from accept to accept through the accept, a product step, a divider
// start, the bit-serial floor divider steps (x and y in parallel), a rounding step, a
// range check with the RAM read and one write back. A key out of range skips the write
// back; an ignored cell or a finish ends at its accept; a read_row reads, then responds.
// Reset is synchronous and clears both bitmaps at once through per-row valid bits.
// A pending response holds the next read_row in its response state only.
`default_nettype none
module coarse_occupancy_change_map_core (
   input  wire logic clock,
   input  wire logic reset,
   ocm_req_if.sink   req_ch,
   ocm_rsp_if.source rsp_ch,
   ocm_csr_if.sink   csr_ch
);
   import ocm_pkg::*;

   state_type state_ff, state_in;

   logic signed [31:0] origin_x_ff, origin_y_ff;
   logic [15:0]        cell_res_ff, key_size_ff;
   logic signed [15:0] base_x_ff, base_y_ff;

   logic [1:0]         op_ff;
   logic signed [7:0]  cost_ff;
   logic [15:0]        col_ff, row_ff;
   logic [PROD_W-1:0]  prod_x_ff, prod_y_ff;
   logic [COL_AW-1:0]  kx_ff, kx_in;
   logic               ridx_ok_ff;
   logic [MAP_COLS-1:0] mask_ff;
   logic               map_ready_ff;
   logic [MAP_ROWS-1:0] base_vld_ff, chg_vld_ff;
   logic [ROW_AW-1:0]  rd_addr, rd_addr_ff;
   logic               div_go_ff;

   logic               rsp_valid_ff;
   logic [MASK_W-1:0]  rsp_mask_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_ready_flag_ff;

   logic               accept;
   logic               div_start;
   logic [15:0]        ks_eff;
   logic [DEN_W-1:0]   den;
   logic signed [NUM_W-1:0] num_x, num_y;
   div_res_type        res_x, res_y;
   logic signed [KEY_W-1:0] key_x, key_y;
   logic               in_range;

   logic [MAP_COLS-1:0] base_raw, chg_raw, base_row, chg_row, bit_mask;
   logic               base_we, chg_we;
   logic [MAP_COLS-1:0] base_wdata, chg_wdata;
   logic               rsp_load;

   assign accept = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= ORIGIN_RESET;
         origin_y_ff <= ORIGIN_RESET;
         cell_res_ff <= RES_RESET;
         key_size_ff <= KEY_RESET;
         base_x_ff   <= BASE_RESET;
         base_y_ff   <= BASE_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_ORIGIN_X:   origin_x_ff <= csr_ch.data;
            REG_ORIGIN_Y:   origin_y_ff <= csr_ch.data;
            REG_CELL_RES:   cell_res_ff <= csr_ch.data[15:0];
            REG_KEY_SIZE:   key_size_ff <= csr_ch.data[15:0];
            REG_KEY_BASE_X: base_x_ff   <= csr_ch.data[15:0];
            REG_KEY_BASE_Y: base_y_ff   <= csr_ch.data[15:0];
            default: ;
         endcase
      end
   end

   assign ks_eff = (key_size_ff == 16'd0) ? 16'd1 : key_size_ff;
   assign den    = {ks_eff, 1'b0};
   assign num_x  = {{2{origin_x_ff[31]}}, origin_x_ff, 1'b0} + $signed({2'b00, prod_x_ff});
   assign num_y  = {{2{origin_y_ff[31]}}, origin_y_ff, 1'b0} + $signed({2'b00, prod_y_ff});

   ocm_div u_div_x (
      .clock (clock), .reset (reset), .start (div_start),
      .num (num_x), .den (den), .res (res_x)
   );
   ocm_div u_div_y (
      .clock (clock), .reset (reset), .start (div_start),
      .num (num_y), .den (den), .res (res_y)
   );

   assign key_x = KEY_W'(res_x.quot) - KEY_W'(base_x_ff);
   assign key_y = KEY_W'(res_y.quot) - KEY_W'(base_y_ff);
   assign in_range = !key_x[KEY_W-1] && !key_y[KEY_W-1]
                     && (key_x < $signed(KEY_W'(MAP_COLS)))
                     && (key_y < $signed(KEY_W'(MAP_ROWS)));

   ocm_ram #(.WIDTH(MAP_COLS), .DEPTH(MAP_ROWS)) u_base_ram (
      .clock (clock), .we (base_we), .waddr (rd_addr_ff), .wdata (base_wdata),
      .raddr (rd_addr), .rdata (base_raw)
   );
   ocm_ram #(.WIDTH(MAP_COLS), .DEPTH(MAP_ROWS)) u_chg_ram (
      .clock (clock), .we (chg_we), .waddr (rd_addr_ff), .wdata (chg_wdata),
      .raddr (rd_addr), .rdata (chg_raw)
   );

   assign base_row = base_vld_ff[rd_addr_ff] ? base_raw : '0;
   assign chg_row  = chg_vld_ff[rd_addr_ff] ? chg_raw : '0;
   assign bit_mask = MAP_COLS'(1) << kx_ff;
   assign rd_addr  = (state_ff == ST_IDLE) ? ROW_AW'(req_ch.read_index)
                                           : ROW_AW'(key_y);
   assign kx_in    = COL_AW'(key_x);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (opcode_type'(req_ch.opcode))
                  OP_READ_ROW: state_in = ST_READ;
                  OP_FINISH:   state_in = ST_IDLE;
                  OP_BASELINE: state_in = map_ready_ff ? ST_IDLE : ST_MUL;
                  OP_UPDATE:   state_in = map_ready_ff ? ST_MUL : ST_IDLE;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_MUL:  state_in = ST_DIV;
         ST_DIV: begin
            if (res_x.done) begin
               state_in = in_range ? ST_READ : ST_IDLE;
            end
         end
         ST_READ: state_in = (opcode_type'(op_ff) == OP_READ_ROW) ? ST_RESP : ST_IDLE;
         ST_RESP: state_in = rsp_load ? ST_IDLE : ST_RESP;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ch.ready = (state_ff == ST_IDLE);
      div_start    = div_go_ff;
      rsp_load     = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ch.ready);
      base_we      = 1'b0;
      chg_we       = 1'b0;
      base_wdata   = base_row | bit_mask;
      chg_wdata    = chg_row;
      if (state_ff == ST_READ) begin
         case (opcode_type'(op_ff))
            OP_BASELINE: base_we = (cost_ff == OCCUPIED_COST);
            OP_UPDATE: begin
               if (cost_ff == OCCUPIED_COST) begin
                  chg_we    = ((base_row & bit_mask) == '0);
                  chg_wdata = chg_row | bit_mask;
               end else if (cost_ff <= 8'sd0) begin
                  chg_we    = 1'b1;
                  chg_wdata = chg_row & ~bit_mask;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         map_ready_ff <= 1'b0;
         base_vld_ff  <= '0;
         chg_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         div_go_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         div_go_ff <= (state_ff == ST_MUL);
         if (accept && opcode_type'(req_ch.opcode) == OP_FINISH) begin
            map_ready_ff <= 1'b1;
         end
         if (base_we) begin
            base_vld_ff[rd_addr_ff] <= 1'b1;
         end
         if (chg_we) begin
            chg_vld_ff[rd_addr_ff] <= 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      rd_addr_ff <= rd_addr;
      if (accept) begin
         op_ff      <= req_ch.opcode;
         cost_ff    <= req_ch.cost;
         col_ff     <= req_ch.grid_col;
         row_ff     <= req_ch.grid_row;
         ridx_ok_ff <= (32'(req_ch.read_index) < 32'(MAP_ROWS));
      end
      if (state_ff == ST_MUL) begin
         prod_x_ff <= {col_ff, 1'b1} * cell_res_ff;
         prod_y_ff <= {row_ff, 1'b1} * cell_res_ff;
      end
      if (state_ff == ST_DIV) begin
         kx_ff <= kx_in;
      end
      if (state_ff == ST_READ) begin
         mask_ff <= ridx_ok_ff ? chg_row : '0;
      end
      if (rsp_load) begin
         rsp_mask_ff       <= MASK_W'(mask_ff);
         rsp_count_ff      <= popcount(mask_ff);
         rsp_ready_flag_ff <= map_ready_ff;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.row_mask  = rsp_mask_ff;
   assign rsp_ch.row_count = rsp_count_ff;
   assign rsp_ch.map_ready = rsp_ready_flag_ff;

   a_write_in_read: assert property (@(posedge clock) disable iff (reset)
      (base_we || chg_we) |-> (state_ff == ST_READ))
      else $error("bitmap written outside the read-modify-write state");
   a_ready_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(map_ready_ff))
      else $error("map ready flag dropped");
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(base_we && chg_we))
      else $error("both bitmaps written by one word");
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (opcode_type'(op_ff) == OP_READ_ROW))
      else $error("response loaded for a word that is not a row read");
endmodule
`default_nettype wire
